[rtl/hafq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hafq_pkg
// Shared constants, widths and the arctangent table for the hinge angle block.
// ----------------------------------------------------------------------------
package hafq_pkg;

    localparam int QUAT_FRAC_BITS_DEF  = 14;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ATAN_LEN            = 24;

    // Datapath widths
    localparam int QW = 64;   // packed quaternion
    localparam int CW = 28;   // rotation matrix entry
    localparam int DW = 64;   // dot products and CORDIC x, y
    localparam int ZW = 36;   // CORDIC angle accumulator, radians * 2^30
    localparam int MW = 34;   // multiplier operand
    localparam int PW = 68;   // multiplier product
    localparam int AW = 20;   // working hinge angle
    localparam int LW = 17;   // hinge angle and limit fields
    localparam int SW = 5;    // CORDIC step counter

    localparam longint PI_Q30 = 64'sd3373259426;

    // Configuration register indexes
    localparam logic [1:0] REG_LOWER_LIMIT = 2'd0;
    localparam logic [1:0] REG_UPPER_LIMIT = 2'd1;

    localparam logic signed [LW-1:0] LOWER_LIMIT_RST = 17'sd0;
    localparam logic signed [LW-1:0] UPPER_LIMIT_RST = 17'sd25736;

    function automatic logic signed [ZW-1:0] f_atan_q30(input logic [SW-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837830;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775852;
            5'd7:    v = 36'sd8388438;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048576;
            5'd11:   v = 36'sd524288;
            5'd12:   v = 36'sd262144;
            5'd13:   v = 36'sd131072;
            5'd14:   v = 36'sd65536;
            5'd15:   v = 36'sd32768;
            5'd16:   v = 36'sd16384;
            5'd17:   v = 36'sd8192;
            5'd18:   v = 36'sd4096;
            5'd19:   v = 36'sd2048;
            5'd20:   v = 36'sd1024;
            5'd21:   v = 36'sd512;
            5'd22:   v = 36'sd256;
            5'd23:   v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/hafq_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hafq_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module hafq_mul
    import hafq_pkg::*;
(
    input  wire                 i_clk,
    input  wire signed [MW-1:0] i_a,
    input  wire signed [MW-1:0] i_b,
    output logic signed [PW-1:0] o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= i_a * i_b;
    end

endmodule
`default_nettype wire

[rtl/hafq_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hafq_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle at 2^30.
// ----------------------------------------------------------------------------
module hafq_cordic
    import hafq_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire signed [DW-1:0]  i_c,
    input  wire signed [DW-1:0]  i_s,
    output logic                 o_done,
    output logic signed [ZW-1:0] o_z
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    logic signed [DW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [SW-1:0]        r_i;
    logic                 r_busy;
    logic signed [DW-1:0] w_sx, w_sy;

    assign w_sx = r_x >>> r_i;
    assign w_sy = r_y >>> r_i;
    assign o_z  = r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_i    <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                // fold the left half plane onto the right one
                if (i_c < 0) begin
                    r_x <= -i_c;
                    r_y <= -i_s;
                    r_z <= (i_s >= 0) ? ZW'(PI_Q30) : -ZW'(PI_Q30);
                end else begin
                    r_x <= i_c;
                    r_y <= i_s;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_i == SW'(NSTEP)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    if (r_y > 0) begin
                        r_x <= r_x + w_sy;
                        r_y <= r_y - w_sx;
                        r_z <= r_z + f_atan_q30(r_i);
                    end else begin
                        r_x <= r_x - w_sy;
                        r_y <= r_y + w_sx;
                        r_z <= r_z - f_atan_q30(r_i);
                    end
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/hinge_angle_from_quaternions.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hinge_angle_from_quaternions
// Hinge angle between a base tag and a lid tag from their orientations.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+-----------------------------------
//  s (in)   | in  | i_s_tvalid / o_s_tready  | tdata quats, tuser seen flags
//  m (out)  | out | o_m_tvalid / i_m_tready  | tdata angle, tuser status flags
//  cfg      | in  | i_cfg_valid / o_cfg_ready| index, 17-bit limit
//
// One item at a time. The time from transfer to result is set by the shared
// multiplier (20 quaternion products, 6 dot products, 2 squares), the
// one-step-per-cycle CORDIC (CORDIC_STEPS capped at 24) and up to 2 unwrap
// steps. Degenerate geometry skips the CORDIC.
// An item with no usable tags has its result valid in the cycle after its transfer.
// o_s_tready is high only when idle; a stalled result holds until taken.
// Reset is synchronous and clears the remembered base and angle.
// ----------------------------------------------------------------------------
module hinge_angle_from_quaternions
    import hafq_pkg::*;
#(
    parameter int QUAT_FRAC_BITS  = QUAT_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [191:0] i_s_tdata,   // base_quat, inner_quat, outer_quat
    input  wire  [2:0]   i_s_tuser,   // base_seen, inner_seen, outer_seen
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [23:0]  o_m_tdata,   // lid angle, zero fill
    output logic [2:0]   o_m_tuser,   // angle_valid, used_outer_tag, used_stored_base
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [16:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_QPROD, S_COL, S_DOT, S_NZ, S_CSTART, S_CWAIT,
        S_SHIFT, S_FOLD, S_WRAP, S_UNWRAP, S_CLAMP, S_OUT
    } t_state;

    localparam int NZ_SH  = 4 * QUAT_FRAC_BITS - 40;
    localparam logic [64:0] NZ_THR = (NZ_SH > 0) ? (65'd1 << ((NZ_SH > 0) ? NZ_SH : 0))
                                                 : 65'd1;
    localparam int RSH    = 30 - ANGLE_FRAC_BITS;
    localparam longint PI_L = (PI_Q30 + (64'sd1 <<< (RSH - 1))) >>> RSH;
    localparam logic signed [ZW-1:0] PI_Z  = ZW'(PI_L);
    localparam logic signed [AW-1:0] PI_A  = AW'(PI_L);
    localparam logic signed [AW-1:0] TPI_A = AW'(2 * PI_L);
    localparam logic signed [DW-1:0] LIM   = 64'sd1 <<< 31;

    // product slots per quaternion
    localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_WW = 3, P_XY = 4;
    localparam int P_ZW = 5, P_XZ = 6, P_YW = 7, P_YZ = 8, P_XW = 9;
    localparam int NPROD = 10;

    t_state r_state;
    logic [4:0] r_step;
    logic [QW-1:0] r_stored_base, r_base, r_lid;
    logic r_base_known, r_angle_known, r_outer, r_used_stored;
    logic signed [LW-1:0] r_lower, r_upper, r_prev;
    logic signed [31:0] r_pp [2*NPROD];
    logic signed [CW-1:0] r_b0 [3];
    logic signed [CW-1:0] r_b2 [3];
    logic signed [CW-1:0] r_l0 [3];
    logic signed [DW-1:0] r_c, r_s;
    logic [63:0] r_sq;
    logic signed [ZW-1:0] r_z;
    logic signed [AW-1:0] r_a, r_ang;
    logic r_out_valid, r_out_ok, r_out_outer, r_out_stored;
    logic signed [LW-1:0] r_out_angle;

    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_prod;
    logic signed [DW-1:0] w_p64, w_cabs, w_sabs;
    logic [QW-1:0] w_q;
    logic [3:0] w_j;
    logic signed [15:0] w_px, w_py, w_pz, w_pw;
    logic signed [35:0] w_e [2*NPROD];
    logic signed [CW-1:0] w_col [9];
    logic w_big, w_cdone;
    logic signed [ZW-1:0] w_cz, w_rz, w_az;
    logic signed [AW-1:0] w_a2, w_t, w_t1, w_t2, w_diff, w_lo, w_hi;
    logic w_in_ok;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {7'd0, r_out_angle};
    assign o_m_tuser   = {r_out_stored, r_out_outer, r_out_ok};

    hafq_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    hafq_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CSTART),
        .i_c     (r_c),
        .i_s     (r_s),
        .o_done  (w_cdone),
        .o_z     (w_cz)
    );

    function automatic logic signed [CW-1:0] f_round(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = v + (36'sd1 <<< (QUAT_FRAC_BITS - 1));
        return CW'(t >>> QUAT_FRAC_BITS);
    endfunction

    function automatic logic signed [MW-1:0] f_ext16(input logic signed [15:0] v);
        return {{(MW-16){v[15]}}, v};
    endfunction

    function automatic logic signed [MW-1:0] f_extc(input logic signed [CW-1:0] v);
        return {{(MW-CW){v[CW-1]}}, v};
    endfunction

    assign w_p64  = $signed(w_prod[DW-1:0]);
    assign w_cabs = (r_c < 0) ? -r_c : r_c;
    assign w_sabs = (r_s < 0) ? -r_s : r_s;
    assign w_big  = (r_c >= LIM) || (r_c <= -LIM) || (r_s >= LIM) || (r_s <= -LIM);
    assign w_in_ok = (i_s_tuser[0] || r_base_known) && (i_s_tuser[1] || i_s_tuser[2]);

    // operand select for the shared multiplier
    always_comb begin
        w_q  = (r_step < 5'd10) ? r_base : r_lid;
        w_j  = (r_step < 5'd10) ? r_step[3:0] : 4'(r_step - 5'd10);
        w_px = $signed(w_q[63:48]);
        w_py = $signed(w_q[47:32]);
        w_pz = $signed(w_q[31:16]);
        w_pw = $signed(w_q[15:0]);
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_QPROD: begin
                case (w_j)
                    4'd0:    begin w_ma = f_ext16(w_px); w_mb = f_ext16(w_px); end
                    4'd1:    begin w_ma = f_ext16(w_py); w_mb = f_ext16(w_py); end
                    4'd2:    begin w_ma = f_ext16(w_pz); w_mb = f_ext16(w_pz); end
                    4'd3:    begin w_ma = f_ext16(w_pw); w_mb = f_ext16(w_pw); end
                    4'd4:    begin w_ma = f_ext16(w_px); w_mb = f_ext16(w_py); end
                    4'd5:    begin w_ma = f_ext16(w_pz); w_mb = f_ext16(w_pw); end
                    4'd6:    begin w_ma = f_ext16(w_px); w_mb = f_ext16(w_pz); end
                    4'd7:    begin w_ma = f_ext16(w_py); w_mb = f_ext16(w_pw); end
                    4'd8:    begin w_ma = f_ext16(w_py); w_mb = f_ext16(w_pz); end
                    4'd9:    begin w_ma = f_ext16(w_px); w_mb = f_ext16(w_pw); end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            S_DOT: begin
                case (r_step[2:0])
                    3'd0:    begin w_ma = f_extc(r_b0[0]); w_mb = f_extc(r_l0[0]); end
                    3'd1:    begin w_ma = f_extc(r_b0[1]); w_mb = f_extc(r_l0[1]); end
                    3'd2:    begin w_ma = f_extc(r_b0[2]); w_mb = f_extc(r_l0[2]); end
                    3'd3:    begin w_ma = f_extc(r_b2[0]); w_mb = f_extc(r_l0[0]); end
                    3'd4:    begin w_ma = f_extc(r_b2[1]); w_mb = f_extc(r_l0[1]); end
                    3'd5:    begin w_ma = f_extc(r_b2[2]); w_mb = f_extc(r_l0[2]); end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            S_NZ: begin
                if (r_step == 5'd0) begin
                    w_ma = {2'b00, w_cabs[31:0]};
                    w_mb = {2'b00, w_cabs[31:0]};
                end else begin
                    w_ma = {2'b00, w_sabs[31:0]};
                    w_mb = {2'b00, w_sabs[31:0]};
                end
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // rotation matrix entries from the stored products
    always_comb begin
        for (int k = 0; k < 2*NPROD; k++) begin
            w_e[k] = {{4{r_pp[k][31]}}, r_pp[k]};
        end
        w_col[0] = f_round(w_e[P_WW] + w_e[P_XX] - w_e[P_YY] - w_e[P_ZZ]);
        w_col[1] = f_round((w_e[P_XY] + w_e[P_ZW]) <<< 1);
        w_col[2] = f_round((w_e[P_XZ] - w_e[P_YW]) <<< 1);
        w_col[3] = f_round((w_e[P_XZ] + w_e[P_YW]) <<< 1);
        w_col[4] = f_round((w_e[P_YZ] - w_e[P_XW]) <<< 1);
        w_col[5] = f_round(w_e[P_WW] - w_e[P_XX] - w_e[P_YY] + w_e[P_ZZ]);
        w_col[6] = f_round(w_e[NPROD+P_WW] + w_e[NPROD+P_XX]
                           - w_e[NPROD+P_YY] - w_e[NPROD+P_ZZ]);
        w_col[7] = f_round((w_e[NPROD+P_XY] + w_e[NPROD+P_ZW]) <<< 1);
        w_col[8] = f_round((w_e[NPROD+P_XZ] - w_e[NPROD+P_YW]) <<< 1);
    end

    // angle post-processing
    always_comb begin
        w_rz = r_z + (36'sd1 <<< (RSH - 1));
        w_az = w_rz >>> RSH;
        if (w_az > PI_Z)  w_az = PI_Z;
        if (w_az < -PI_Z) w_az = -PI_Z;
        w_a2 = (r_a < 0) ? r_a + TPI_A : r_a;
        w_t  = PI_A - w_a2 - (r_outer ? PI_A : '0);
        w_t1 = (r_ang < 0) ? r_ang + TPI_A : r_ang;
        w_t1 = (w_t1 < 0) ? w_t1 + TPI_A : w_t1;
        w_t2 = (w_t1 >= TPI_A) ? w_t1 - TPI_A : w_t1;
        w_diff = r_ang - AW'(r_prev);
        w_lo = AW'(r_lower);
        w_hi = AW'(r_upper);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step        <= '0;
            r_stored_base <= '0;
            r_base_known  <= 1'b0;
            r_angle_known <= 1'b0;
            r_prev        <= '0;
            r_lower       <= LOWER_LIMIT_RST;
            r_upper       <= UPPER_LIMIT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_LOWER_LIMIT: r_lower <= $signed(i_cfg_data);
                    REG_UPPER_LIMIT: r_upper <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        if (i_s_tuser[0]) begin
                            r_stored_base <= i_s_tdata[63:0];
                            r_base_known  <= 1'b1;
                        end
                        r_base        <= i_s_tuser[0] ? i_s_tdata[63:0] : r_stored_base;
                        r_used_stored <= !i_s_tuser[0];
                        r_lid         <= i_s_tuser[1] ? i_s_tdata[127:64] : i_s_tdata[191:128];
                        r_outer       <= !i_s_tuser[1];
                        r_step        <= '0;
                        if (w_in_ok) begin
                            r_state <= S_QPROD;
                        end else begin
                            // no usable tag pair: answer with zeros
                            r_out_valid  <= 1'b1;
                            r_out_ok     <= 1'b0;
                            r_out_angle  <= '0;
                            r_out_outer  <= 1'b0;
                            r_out_stored <= 1'b0;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_QPROD: begin
                    if (r_step != 5'd0) begin
                        r_pp[r_step - 5'd1] <= w_prod[31:0];
                    end
                    if (r_step == 5'(2*NPROD)) begin
                        r_state <= S_COL;
                    end
                    r_step <= r_step + 5'd1;
                end
                S_COL: begin
                    r_b0[0] <= w_col[0];
                    r_b0[1] <= w_col[1];
                    r_b0[2] <= w_col[2];
                    r_b2[0] <= w_col[3];
                    r_b2[1] <= w_col[4];
                    r_b2[2] <= w_col[5];
                    r_l0[0] <= w_col[6];
                    r_l0[1] <= w_col[7];
                    r_l0[2] <= w_col[8];
                    r_c     <= '0;
                    r_s     <= '0;
                    r_step  <= '0;
                    r_state <= S_DOT;
                end
                S_DOT: begin
                    if (r_step >= 5'd1 && r_step <= 5'd3) begin
                        r_c <= r_c + w_p64;
                    end else if (r_step >= 5'd4) begin
                        r_s <= r_s - w_p64;
                    end
                    if (r_step == 5'd6) begin
                        r_step  <= '0;
                        r_state <= S_NZ;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_NZ: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd1) begin
                        r_sq <= w_prod[63:0];
                    end
                    if (r_step == 5'd2) begin
                        if (!w_big && ({1'b0, r_sq} + {1'b0, w_prod[63:0]} < NZ_THR)) begin
                            // degenerate geometry: angle is zero, no offset
                            r_ang   <= '0;
                            r_state <= S_UNWRAP;
                        end else begin
                            r_state <= S_CSTART;
                        end
                    end
                end
                S_CSTART: begin
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    if (w_cdone) begin
                        r_z     <= w_cz;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_a     <= AW'(w_az);
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_ang   <= w_t;
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    r_ang   <= w_t2;
                    r_state <= S_UNWRAP;
                end
                S_UNWRAP: begin
                    // step toward the last output one turn at a time
                    if (r_angle_known && w_diff > PI_A) begin
                        r_ang <= r_ang - TPI_A;
                    end else if (r_angle_known && w_diff < -PI_A) begin
                        r_ang <= r_ang + TPI_A;
                    end else begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (r_ang < w_lo) begin
                        r_prev      <= r_lower;
                        r_out_angle <= r_lower;
                    end else if (r_ang > w_hi) begin
                        r_prev      <= r_upper;
                        r_out_angle <= r_upper;
                    end else begin
                        r_prev      <= LW'(r_ang);
                        r_out_angle <= LW'(r_ang);
                    end
                    r_angle_known <= 1'b1;
                    r_out_valid   <= 1'b1;
                    r_out_ok      <= 1'b1;
                    r_out_outer   <= r_outer;
                    r_out_stored  <= r_used_stored;
                    r_state       <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hinge angle testbench
// Streams tag orientation sets into the block with random gaps and output
// stalls, predicts each hinge angle with an independent fixed-point model,
// and checks every result field in order. Limits are rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
    import hafq_pkg::*;

    localparam int QF = 14;
    localparam int AF = 13;
    localparam int STEPS = 16;
    localparam longint PI_A = 25736;

    typedef struct packed {
        logic [2:0]   flags;   // outer_seen, inner_seen, base_seen
        logic [191:0] quats;   // outer, inner, base
    } pose_set_t;

    typedef struct packed {
        logic               valid;
        logic signed [16:0] angle;
        logic               outer;
        logic               stored;
    } hinge_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [16:0]  cfg_data = '0;

    hinge_angle_from_quaternions dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [63:0]        base_pose;
    logic               base_held;
    logic signed [16:0] last_angle;
    logic               angle_held;
    logic signed [16:0] lo_limit;
    logic signed [16:0] hi_limit;

    pose_set_t pending_sets[$];
    hinge_t    expected_angles[$];
    int        mismatches = 0;
    int        hold_off = 0;

    // transfers seen at the last rising edge
    logic s_tready_q = 1'b0;
    logic m_tready_q = 1'b0;

    function automatic longint fdiv(longint v, int n);
        return v >>> n;   // arithmetic shift is a floor shift
    endfunction

    function automatic longint rnd(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic void columns(input logic [63:0] q,
                                    output longint c0[3], output longint c2[3]);
        longint x, y, z, w;
        x = longint'($signed(q[63:48]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[31:16]));
        w = longint'($signed(q[15:0]));
        c0[0] = rnd(w*w + x*x - y*y - z*z, QF);
        c0[1] = rnd(2*(x*y + z*w), QF);
        c0[2] = rnd(2*(x*z - y*w), QF);
        c2[0] = rnd(2*(x*z + y*w), QF);
        c2[1] = rnd(2*(y*z - x*w), QF);
        c2[2] = rnd(w*w - x*x - y*y + z*z, QF);
    endfunction

    function automatic longint atan_q30(int i);
        longint t[24] = '{843314857, 497837830, 263043837, 133525159, 67021687,
            33543516, 16775852, 8388438, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128};
        return t[i];
    endfunction

    function automatic longint vector_angle(longint s, longint c);
        longint x, y, z, nx, ny;
        x = c; y = s; z = 0;
        if (x < 0) begin
            x = -x; y = -y;
            z = (s >= 0) ? PI_Q30 : -PI_Q30;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            if (y > 0) begin
                nx = x + fdiv(y, i); ny = y - fdiv(x, i); z += atan_q30(i);
            end else begin
                nx = x - fdiv(y, i); ny = y + fdiv(x, i); z -= atan_q30(i);
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    function automatic hinge_t predict_hinge(pose_set_t p);
        hinge_t r;
        logic [63:0] base, lid;
        logic outer, stored;
        longint b0[3], b2[3], l0[3], l2[3], c, s, a, ang, lim;
        r = '0;
        stored = 1'b0;
        if (p.flags[0]) begin
            base = p.quats[63:0];
            base_pose = base;
            base_held = 1'b1;
        end else if (base_held) begin
            base = base_pose; stored = 1'b1;
        end else begin
            return r;
        end
        if (p.flags[1]) begin
            lid = p.quats[127:64]; outer = 1'b0;
        end else if (p.flags[2]) begin
            lid = p.quats[191:128]; outer = 1'b1;
        end else begin
            return r;
        end
        columns(base, b0, b2);
        columns(lid, l0, l2);
        c = b0[0]*l0[0] + b0[1]*l0[1] + b0[2]*l0[2];
        s = -(b2[0]*l0[0] + b2[1]*l0[1] + b2[2]*l0[2]);
        lim = 64'sd1 <<< 31;
        if (c < lim && c > -lim && s < lim && s > -lim && c*c + s*s < (64'sd1 <<< 16)) begin
            ang = 0;
        end else begin
            a = rnd(vector_angle(s, c), 30 - AF);
            if (a > PI_A) a = PI_A;
            if (a < -PI_A) a = -PI_A;
            if (a < 0) a += 2*PI_A;
            ang = PI_A - a;
            if (outer) ang -= PI_A;
            if (ang < 0) ang += 2*PI_A;
            if (ang < 0) ang += 2*PI_A;
            if (ang >= 2*PI_A) ang -= 2*PI_A;
        end
        if (angle_held) begin
            while (ang - last_angle > PI_A) ang -= 2*PI_A;
            while (ang - last_angle < -PI_A) ang += 2*PI_A;
        end
        if (ang < lo_limit) ang = lo_limit;
        else if (ang > hi_limit) ang = hi_limit;
        last_angle = 17'(ang);
        angle_held = 1'b1;
        r.valid = 1'b1; r.angle = 17'(ang); r.outer = outer; r.stored = stored;
        return r;
    endfunction

    function automatic logic [63:0] random_quat();
        logic [63:0] q;
        case ($urandom_range(0, 3))
            0: q = {$urandom, $urandom};
            1: q = {16'(16'sd0 + $signed(17'($urandom_range(0, 8192)) - 17'sd4096)),
                    16'(16'sd0 + $signed(17'($urandom_range(0, 8192)) - 17'sd4096)),
                    16'(16'sd0 + $signed(17'($urandom_range(0, 8192)) - 17'sd4096)),
                    16'(16'sd0 + $signed(17'($urandom_range(0, 8192)) - 17'sd4096))};
            default: begin
                // rotation about y, not normalized, with small x and z noise
                q = {16'($signed(6'($urandom))), 16'($urandom_range(0, 16384)),
                     16'($signed(6'($urandom))), 16'($urandom_range(0, 16384))};
                if ($urandom_range(0, 1)) q[47:32] = -q[47:32];
            end
        endcase
        return q;
    endfunction

    // driver
    int send_gap = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready_q) begin
                s_tvalid <= 1'b0;
                send_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end else if (!s_tvalid && pending_sets.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    pose_set_t p;
                    p = pending_sets.pop_front();
                    s_tdata <= p.quats;
                    s_tuser <= p.flags;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // capture handshakes at the rising edge
    always @(posedge clk) begin
        s_tready_q <= s_tvalid && s_tready;
        m_tready_q <= m_tvalid && m_tready;
        if (rst_n && s_tvalid && s_tready)
            expected_angles.push_back(predict_hinge(pose_set_t'({s_tuser, s_tdata})));
    end

    // monitor
    int recv_gap = 0;
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            hinge_t got, want;
            got = '{valid: m_tuser[0], angle: $signed(m_tdata[16:0]),
                    outer: m_tuser[1], stored: m_tuser[2]};
            if (expected_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_angles.pop_front();
                if (got !== want || m_tdata[23:17] !== 7'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else if (m_tready_q) begin
            recv_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) recv_gap = 0;
            m_tready <= (recv_gap == 0);
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= (recv_gap == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (pending_sets.size() > 0 || s_tvalid || expected_angles.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_limit(logic [1:0] idx, logic signed [16:0] val);
        @(negedge clk);
        cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_LOWER_LIMIT) lo_limit = val; else hi_limit = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_set(logic [2:0] f, logic [63:0] b, logic [63:0] i, logic [63:0] o);
        pose_set_t p;
        p.flags = f; p.quats = {o, i, b};
        pending_sets.push_back(p);
    endtask

    task automatic queue_random(int n);
        logic [2:0] f;
        for (int k = 0; k < n; k++) begin
            f = 3'($urandom);
            if ($urandom_range(0, 4) != 0) f[1] = f[1] | f[2] ? f[1] : 1'b1;
            queue_set(f, random_quat(), random_quat(), random_quat());
        end
    endtask

    initial begin
        logic [63:0] ident, yrot;
        base_pose = '0; base_held = 1'b0; last_angle = '0; angle_held = 1'b0;
        lo_limit = LOWER_LIMIT_RST; hi_limit = UPPER_LIMIT_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        ident = {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
        yrot  = {16'sd0, 16'sd11585, 16'sd0, 16'sd11585};
        // no base ever seen, then no lid, then each tag choice and degenerate poses
        queue_set(3'b010, '0, ident, ident);
        queue_set(3'b001, ident, ident, ident);
        queue_set(3'b011, ident, yrot, ident);
        queue_set(3'b100, ident, ident, yrot);
        queue_set(3'b110, ident, yrot, ident);
        queue_set(3'b011, ident, '0, ident);
        queue_set(3'b011, '0, yrot, ident);
        queue_set(3'b111, 64'h8000800080008000, 64'h7FFF7FFF7FFF7FFF, ident);
        queue_set(3'b101, 64'hFFFFFFFFFFFFFFFF, ident, 64'h8000000000007FFF);
        queue_set(3'b010, ident, {16'sd0, -16'sd11585, 16'sd0, 16'sd11585}, ident);
        queue_set(3'b010, ident, {16'sd0, 16'sd16384, 16'sd0, 16'sd0}, ident);
        queue_set(3'b000, ident, ident, ident);
        wait_drained();
        write_limit(REG_LOWER_LIMIT, -17'sd51472);
        write_limit(REG_UPPER_LIMIT, 17'sd51472);
        queue_random(250);
        // long receiver stall while the sender keeps offering
        hold_off = 300;
        wait_drained();
        write_limit(REG_LOWER_LIMIT, 17'sd51472);
        write_limit(REG_UPPER_LIMIT, -17'sd51472);
        queue_random(60);
        wait_drained();
        write_limit(REG_LOWER_LIMIT, -17'sd8000);
        write_limit(REG_UPPER_LIMIT, 17'sd30000);
        queue_random(260);
        wait_drained();
        write_limit(REG_LOWER_LIMIT, 17'sd0);
        write_limit(REG_UPPER_LIMIT, 17'sd25736);
        queue_random(270);
        wait_drained();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
